// ----- sv/kci_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_pkg
// Shared types and constants of the keyframe curve interpolator.
// ----------------------------------------------------------------------------
package kci_pkg;

  localparam int VALUE_WIDTH_DEF       = 32;
  localparam int TIME_WIDTH_DEF        = 24;
  localparam int COS_TABLE_ENTRIES_DEF = 256;

  // Fraction bits of the Q0.16 weight and of the Q16.16 values.
  localparam int FRAC_BITS = 16;
  // Weight of one, Q0.16, needs one extra bit.
  localparam int WEIGHT_BITS = FRAC_BITS + 1;
  localparam logic [WEIGHT_BITS-1:0] ONE_Q16 = WEIGHT_BITS'(1 << FRAC_BITS);

  // Pi in Q2.32 for the table build.
  localparam longint unsigned PI_Q32 = 64'd13493037705;

  typedef enum logic [2:0] {
    MODE_HOLD   = 3'd0,
    MODE_LINEAR = 3'd1,
    MODE_FAST   = 3'd2,
    MODE_SLOW   = 3'd3,
    MODE_SMOOTH = 3'd4
  } mode_t;

endpackage

// ----- sv/kci_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_in_if / kci_out_if
// Valid/ready channels carrying one segment query and one curve result.
// ----------------------------------------------------------------------------
interface kci_in_if #(
  parameter int VALUE_WIDTH = kci_pkg::VALUE_WIDTH_DEF,
  parameter int TIME_WIDTH  = kci_pkg::TIME_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    mode;
  logic signed [VALUE_WIDTH-1:0] start_value;
  logic signed [VALUE_WIDTH-1:0] end_value;
  logic [TIME_WIDTH-1:0]         segment_length;
  logic [TIME_WIDTH-1:0]         offset_in_segment;

  modport source (output valid, mode, start_value, end_value, segment_length,
                  offset_in_segment, input ready);
  modport sink (input valid, mode, start_value, end_value, segment_length,
                offset_in_segment, output ready);
endinterface

interface kci_out_if #(
  parameter int VALUE_WIDTH = kci_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] curve_value;
  logic                          error_flag;

  modport source (output valid, curve_value, error_flag, input ready);
  modport sink (input valid, curve_value, error_flag, output ready);
endinterface

// ----- sv/keyframe_curve_interpolator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator_top
// Evaluates one eased keyframe segment per beat in signed Q16.16.
// ----------------------------------------------------------------------------
//   channel   dir   carries
//   in_ch     in    mode, start_value, end_value, segment_length, offset_in_segment
//   out_ch    out   curve_value, error_flag
//
// One beat is accepted per cycle unless the output stalls. The path is an input
// register, 17 divider stages (one quotient bit each), four weight stages and
// three blend stages. Reset clears only the valid bits. When the output register
// holds a beat that is not taken, the whole pipeline stalls and in_ch.ready
// drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module keyframe_curve_interpolator_top #(
  parameter int VALUE_WIDTH       = kci_pkg::VALUE_WIDTH_DEF,
  parameter int TIME_WIDTH        = kci_pkg::TIME_WIDTH_DEF,
  parameter int COS_TABLE_ENTRIES = kci_pkg::COS_TABLE_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst,
  kci_in_if.sink   in_ch,
  kci_out_if.source out_ch
);

  localparam int WB = kci_pkg::WEIGHT_BITS;

  logic en;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Input register with position saturation and error detection.
  logic                          v0;
  logic [2:0]                    mode0;
  logic signed [VALUE_WIDTH-1:0] start0, end0;
  logic [TIME_WIDTH-1:0]         dur0, pos0;
  logic                          err0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0  <= in_ch.mode;
      start0 <= in_ch.start_value;
      end0   <= in_ch.end_value;
      dur0   <= in_ch.segment_length;
      pos0   <= (in_ch.offset_in_segment > in_ch.segment_length) ?
                in_ch.segment_length : in_ch.offset_in_segment;
      err0   <= (in_ch.segment_length == '0) || (in_ch.mode > kci_pkg::MODE_SMOOTH);
    end
  end

  logic                          v_d;
  logic [WB-1:0]                 t_d;
  logic [2:0]                    mode_d;
  logic signed [VALUE_WIDTH-1:0] start_d, end_d;
  logic                          err_d;

  kci_div #(.VALUE_WIDTH(VALUE_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .in_mode   (mode0),
    .in_start  (start0),
    .in_end    (end0),
    .in_dur    (dur0),
    .in_pos    (pos0),
    .in_err    (err0),
    .out_valid (v_d),
    .out_t     (t_d),
    .out_mode  (mode_d),
    .out_start (start_d),
    .out_end   (end_d),
    .out_err   (err_d)
  );

  logic                          v_s;
  logic [WB-1:0]                 w_s;
  logic signed [VALUE_WIDTH-1:0] start_s, end_s;
  logic                          err_s;

  kci_shape #(.VALUE_WIDTH(VALUE_WIDTH), .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)) u_shape (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_d),
    .in_t      (t_d),
    .in_mode   (mode_d),
    .in_start  (start_d),
    .in_end    (end_d),
    .in_err    (err_d),
    .out_valid (v_s),
    .out_w     (w_s),
    .out_start (start_s),
    .out_end   (end_s),
    .out_err   (err_s)
  );

  kci_blend #(.VALUE_WIDTH(VALUE_WIDTH)) u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_s),
    .in_w      (w_s),
    .in_start  (start_s),
    .in_end    (end_s),
    .in_err    (err_s),
    .out_valid (out_ch.valid),
    .out_value (out_ch.curve_value),
    .out_err   (out_ch.error_flag)
  );

endmodule

// ----- sv/kci_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_div
// Pipelined restoring divider: t = pos * 2^16 / dur, one quotient bit a stage.
// ----------------------------------------------------------------------------
module kci_div #(
  parameter int VALUE_WIDTH = kci_pkg::VALUE_WIDTH_DEF,
  parameter int TIME_WIDTH  = kci_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [2:0]                           in_mode,
  input  logic signed [VALUE_WIDTH-1:0]        in_start,
  input  logic signed [VALUE_WIDTH-1:0]        in_end,
  input  logic [TIME_WIDTH-1:0]                in_dur,
  input  logic [TIME_WIDTH-1:0]                in_pos,
  input  logic                                 in_err,
  output logic                                 out_valid,
  output logic [kci_pkg::WEIGHT_BITS-1:0]      out_t,
  output logic [2:0]                           out_mode,
  output logic signed [VALUE_WIDTH-1:0]        out_start,
  output logic signed [VALUE_WIDTH-1:0]        out_end,
  output logic                                 out_err
);

  localparam int QB = kci_pkg::WEIGHT_BITS;

  logic                          v     [0:QB];
  logic [QB-1:0]                 q     [0:QB];
  logic [TIME_WIDTH-1:0]         rem   [0:QB];
  logic [TIME_WIDTH-1:0]         dur   [0:QB];
  logic [2:0]                    mode  [0:QB];
  logic signed [VALUE_WIDTH-1:0] start [0:QB];
  logic signed [VALUE_WIDTH-1:0] endv  [0:QB];
  logic                          err   [0:QB];

  assign v[0]     = in_valid;
  assign q[0]     = '0;
  assign rem[0]   = in_pos;
  assign dur[0]   = in_dur;
  assign mode[0]  = in_mode;
  assign start[0] = in_start;
  assign endv[0]  = in_end;
  assign err[0]   = in_err;

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [TIME_WIDTH:0] cand;
    logic                ge;

    // The first stage compares the position itself, later stages the doubled remainder.
    if (j == 0) begin : g_first
      assign cand = {1'b0, rem[j]};
    end else begin : g_next
      assign cand = {rem[j], 1'b0};
    end
    assign ge = cand >= {1'b0, dur[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]   <= ge ? TIME_WIDTH'(cand - {1'b0, dur[j]}) : cand[TIME_WIDTH-1:0];
        q[j+1]     <= {q[j][QB-2:0], ge};
        dur[j+1]   <= dur[j];
        mode[j+1]  <= mode[j];
        start[j+1] <= start[j];
        endv[j+1]  <= endv[j];
        err[j+1]   <= err[j];
      end
    end
  end

  assign out_valid = v[QB];
  assign out_t     = q[QB];
  assign out_mode  = mode[QB];
  assign out_start = start[QB];
  assign out_end   = endv[QB];
  assign out_err   = err[QB];

`ifndef SYNTH
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_err) |-> (out_t <= kci_pkg::ONE_Q16))
    else $error("quotient above one");
`endif

endmodule

// ----- sv/kci_shape.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_shape
// Turns t into the curve weight: t for linear, zero for hold, squares for fast
// and slow, and a sin-squared table with linear interpolation for smooth.
// ----------------------------------------------------------------------------
module kci_shape #(
  parameter int VALUE_WIDTH       = kci_pkg::VALUE_WIDTH_DEF,
  parameter int COS_TABLE_ENTRIES = kci_pkg::COS_TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [kci_pkg::WEIGHT_BITS-1:0]    in_t,
  input  logic [2:0]                         in_mode,
  input  logic signed [VALUE_WIDTH-1:0]      in_start,
  input  logic signed [VALUE_WIDTH-1:0]      in_end,
  input  logic                               in_err,
  output logic                               out_valid,
  output logic [kci_pkg::WEIGHT_BITS-1:0]    out_w,
  output logic signed [VALUE_WIDTH-1:0]      out_start,
  output logic signed [VALUE_WIDTH-1:0]      out_end,
  output logic                               out_err
);

  localparam int WB = kci_pkg::WEIGHT_BITS;
  localparam int FB = kci_pkg::FRAC_BITS;
  localparam int KW = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int XW = FB + KW;
  localparam int SW = 2 * WB;
  localparam logic [KW-1:0] LastIdx = KW'(COS_TABLE_ENTRIES);

  typedef logic [WB-1:0] rom_t [0:COS_TABLE_ENTRIES];

  // Entry i of the first half: sin^2(pi*i/(2N)) from a Taylor series in Q0.32.
  function automatic logic [WB-1:0] half_entry(input longint unsigned i);
    longint unsigned a, a2, t3, t5, t7, t9, s, s2;
    a  = (kci_pkg::PI_Q32 * i) / (2 * COS_TABLE_ENTRIES);
    a2 = (a * a) >> 32;
    t3 = ((a * a2) >> 32) / 6;
    t5 = ((t3 * a2) >> 32) / 20;
    t7 = ((t5 * a2) >> 32) / 42;
    t9 = ((t7 * a2) >> 32) / 72;
    s  = a - t3 + t5 - t7 + t9;
    if (s > 64'hFFFF_FFFF) begin
      s = 64'hFFFF_FFFF;
    end
    s2 = (s * s) >> 32;
    return WB'((s2 + 64'd32768) >> 16);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= COS_TABLE_ENTRIES; i++) begin
      if (2 * i <= COS_TABLE_ENTRIES) begin
        r[i] = half_entry(longint'(i));
      end else begin
        r[i] = kci_pkg::ONE_Q16 - half_entry(longint'(COS_TABLE_ENTRIES - i));
      end
    end
    return r;
  endfunction

  localparam rom_t SinSq = build_rom();

  // Stage A: squares and table position.
  logic                          va;
  logic [SW-1:0]                 tsq_a, usq_a;
  logic [XW-1:0]                 x_a;
  logic [WB-1:0]                 t_a;
  logic [2:0]                    mode_a;
  logic signed [VALUE_WIDTH-1:0] start_a, end_a;
  logic                          err_a;
  logic [WB-1:0]                 u;

  assign u = kci_pkg::ONE_Q16 - in_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tsq_a   <= in_t * in_t;
      usq_a   <= u * u;
      x_a     <= XW'(in_t) * XW'(COS_TABLE_ENTRIES);
      t_a     <= in_t;
      mode_a  <= in_mode;
      start_a <= in_start;
      end_a   <= in_end;
      err_a   <= in_err;
    end
  end

  // Stage B: table read and polynomial weights.
  logic [KW-1:0]                 k, idx0, idx1;
  logic [WB-1:0]                 w_poly;
  logic                          vb;
  logic [WB-1:0]                 e0_b, e1_b, wp_b;
  logic [FB-1:0]                 f_b;
  logic                          smooth_b;
  logic signed [VALUE_WIDTH-1:0] start_b, end_b;
  logic                          err_b;

  assign k    = x_a[XW-1:FB];
  // Past the last interval both reads land on the final entry.
  assign idx0 = (k >= LastIdx) ? LastIdx : k;
  assign idx1 = (k >= LastIdx) ? LastIdx : KW'(k + 1'b1);

  always_comb begin
    unique case (mode_a)
      kci_pkg::MODE_LINEAR: w_poly = t_a;
      kci_pkg::MODE_FAST:   w_poly = kci_pkg::ONE_Q16 - WB'(usq_a >> FB);
      kci_pkg::MODE_SLOW:   w_poly = WB'(tsq_a >> FB);
      default:              w_poly = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_b     <= SinSq[idx0];
      e1_b     <= SinSq[idx1];
      f_b      <= x_a[FB-1:0];
      wp_b     <= w_poly;
      smooth_b <= mode_a == kci_pkg::MODE_SMOOTH;
      start_b  <= start_a;
      end_b    <= end_a;
      err_b    <= err_a;
    end
  end

  // Stage C: slope times fraction.
  logic                          vc;
  logic signed [WB:0]            slope;
  logic signed [WB+FB+1:0]       prod_c;
  logic [WB-1:0]                 e0_c, wp_c;
  logic                          smooth_c;
  logic signed [VALUE_WIDTH-1:0] start_c, end_c;
  logic                          err_c;

  assign slope = $signed({1'b0, e1_b}) - $signed({1'b0, e0_b});

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_c   <= slope * $signed({1'b0, f_b});
      e0_c     <= e0_b;
      wp_c     <= wp_b;
      smooth_c <= smooth_b;
      start_c  <= start_b;
      end_c    <= end_b;
      err_c    <= err_b;
    end
  end

  // Stage D: final weight.
  logic signed [WB+FB+1:0] w_sum;

  assign w_sum = $signed({{(FB+2){1'b0}}, e0_c}) + (prod_c >>> FB);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w     <= smooth_c ? w_sum[WB-1:0] : wp_c;
      out_start <= start_c;
      out_end   <= end_c;
      out_err   <= err_c;
    end
  end

`ifndef SYNTH
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_err) |-> (out_w <= kci_pkg::ONE_Q16))
    else $error("weight above one");
`endif

endmodule

// ----- sv/kci_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_blend
// Mixes the two keys: start + floor((end - start) * w / 2^16), saturated.
// ----------------------------------------------------------------------------
module kci_blend #(
  parameter int VALUE_WIDTH = kci_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [kci_pkg::WEIGHT_BITS-1:0] in_w,
  input  logic signed [VALUE_WIDTH-1:0]   in_start,
  input  logic signed [VALUE_WIDTH-1:0]   in_end,
  input  logic                            in_err,
  output logic                            out_valid,
  output logic signed [VALUE_WIDTH-1:0]   out_value,
  output logic                            out_err
);

  localparam int WB = kci_pkg::WEIGHT_BITS;
  localparam int FB = kci_pkg::FRAC_BITS;
  localparam int PW = VALUE_WIDTH + 1 + WB + 1;
  localparam logic signed [VALUE_WIDTH+1:0] MaxV = {3'b000, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH+1:0] MinV = {3'b111, {(VALUE_WIDTH-1){1'b0}}};

  // Stage E: key difference.
  logic                          ve;
  logic signed [VALUE_WIDTH:0]   diff_e;
  logic [WB-1:0]                 w_e;
  logic signed [VALUE_WIDTH-1:0] start_e;
  logic                          err_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_e  <= (VALUE_WIDTH+1)'(in_end) - (VALUE_WIDTH+1)'(in_start);
      w_e     <= in_w;
      start_e <= in_start;
      err_e   <= in_err;
    end
  end

  // Stage P: product. An error beat forces a zero weight so start passes through.
  logic                          vp;
  logic signed [PW-1:0]          prod_p;
  logic signed [VALUE_WIDTH-1:0] start_p;
  logic                          err_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_p  <= diff_e * $signed({1'b0, (err_e ? WB'(0) : w_e)});
      start_p <= start_e;
      err_p   <= err_e;
    end
  end

  // Stage F: add and clamp into the output register.
  logic signed [VALUE_WIDTH+1:0] sum;

  assign sum = (VALUE_WIDTH+2)'(start_p) + (VALUE_WIDTH+2)'(prod_p >>> FB);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (sum > MaxV) begin
        out_value <= MaxV[VALUE_WIDTH-1:0];
      end else if (sum < MinV) begin
        out_value <= MinV[VALUE_WIDTH-1:0];
      end else begin
        out_value <= sum[VALUE_WIDTH-1:0];
      end
      out_err <= err_p;
    end
  end

`ifndef SYNTH
  a_err_pass: assert property (@(posedge clk) disable iff (rst)
    (en && vp && err_p) |=> (out_valid && out_err && out_value == $past(start_p)))
    else $error("error beat did not return the start value");
`endif

endmodule

// ----- bench/kci_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_checker
// Watches both channels of the curve interpolator, predicts each result from
// the accepted query beat and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module kci_checker (
  input  logic      clk,
  input  logic      rst,
  kci_in_if         in_ch,
  kci_out_if        out_ch,
  output int        fail_count,
  output int        pending,
  output int        checked
);

  localparam int N  = kci_pkg::COS_TABLE_ENTRIES_DEF;
  localparam int VW = kci_pkg::VALUE_WIDTH_DEF;
  localparam int TW = kci_pkg::TIME_WIDTH_DEF;

  typedef struct packed {
    logic signed [VW-1:0] curve_value;
    logic                 error_flag;
  } curve_result_t;

  curve_result_t expected_curves[$];
  longint unsigned ease_rom[0:N];

  function automatic longint unsigned quarter_sine_sq(longint unsigned i);
    longint unsigned a, a2, t3, t5, t7, t9, s, s2;
    a  = (kci_pkg::PI_Q32 * i) / (2 * N);
    a2 = (a * a) >> 32;
    t3 = ((a * a2) >> 32) / 6;
    t5 = ((t3 * a2) >> 32) / 20;
    t7 = ((t5 * a2) >> 32) / 42;
    t9 = ((t7 * a2) >> 32) / 72;
    s  = a - t3 + t5 - t7 + t9;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    s2 = (s * s) >> 32;
    return (s2 + 32768) >> 16;
  endfunction

  initial begin
    for (int i = 0; i <= N; i++) begin
      if (2 * i <= N) ease_rom[i] = quarter_sine_sq(i);
      else ease_rom[i] = 65536 - quarter_sine_sq(N - i);
    end
  end

  function automatic longint unsigned smooth_ease(longint unsigned t);
    longint unsigned x, k, f, e0, e1;
    x = t * N;
    k = x >> 16;
    f = x & 64'hFFFF;
    if (k >= N) return ease_rom[N];
    e0 = ease_rom[k];
    e1 = ease_rom[k+1];
    if (e1 >= e0) return e0 + (((e1 - e0) * f) >> 16);
    return e0 - (((e0 - e1) * f + 64'hFFFF) >> 16);
  endfunction

  function automatic curve_result_t eval_segment(logic [2:0] mode,
      logic signed [VW-1:0] start_v,
      logic signed [VW-1:0] end_v,
      logic [TW-1:0] dur, logic [TW-1:0] pos);
    curve_result_t r;
    longint unsigned t, w, u, m, q, rem, p, d;
    longint s, e, diff, res;
    s = start_v;
    e = end_v;
    r.curve_value = start_v;
    r.error_flag  = 1'b1;
    if (dur == 0 || mode > kci_pkg::MODE_SMOOTH) return r;
    p = pos;
    d = dur;
    if (p > d) p = d;
    t = (p << 16) / d;
    case (kci_pkg::mode_t'(mode))
      kci_pkg::MODE_LINEAR: w = t;
      kci_pkg::MODE_FAST: begin
        u = 65536 - t;
        w = 65536 - ((u * u) >> 16);
      end
      kci_pkg::MODE_SLOW:   w = (t * t) >> 16;
      kci_pkg::MODE_SMOOTH: w = smooth_ease(t);
      default:              w = 0;
    endcase
    diff = e - s;
    if (diff >= 0) begin
      m = diff;
      q = m >> 16;
      rem = m & 64'hFFFF;
      res = s + longint'(q * w + ((rem * w) >> 16));
    end else begin
      m = -diff;
      q = m >> 16;
      rem = m & 64'hFFFF;
      res = s - longint'(q * w + ((rem * w + 64'hFFFF) >> 16));
    end
    if (res < -(64'sd1 <<< (VW - 1))) res = -(64'sd1 <<< (VW - 1));
    if (res > (64'sd1 <<< (VW - 1)) - 1) res = (64'sd1 <<< (VW - 1)) - 1;
    r.curve_value = res[VW-1:0];
    r.error_flag  = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    curve_result_t exp_r;
    if (rst) begin
      fail_count <= 0;
      checked    <= 0;
      pending    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_curves.push_back(eval_segment(in_ch.mode, in_ch.start_value,
            in_ch.end_value, in_ch.segment_length, in_ch.offset_in_segment));
      if (out_ch.valid && out_ch.ready) begin
        checked <= checked + 1;
        if (expected_curves.size() == 0) begin
          $display("%0t: result beat with nothing expected: value %h flag %b", $time,
                   out_ch.curve_value, out_ch.error_flag);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_curves.pop_front();
          if (exp_r.curve_value !== out_ch.curve_value ||
              exp_r.error_flag !== out_ch.error_flag) begin
            $display("%0t: mismatch: expected value %h flag %b, got value %h flag %b",
                     $time, exp_r.curve_value, exp_r.error_flag,
                     out_ch.curve_value, out_ch.error_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_curves.size();
    end
  end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random segment queries into the curve interpolator
// under varying input gaps and output back-pressure, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, checked;
  int   cycles = 0;
  int   sent = 0;
  int   send_idle_pct = 17;
  int   recv_idle_pct = 62;
  int   hold_cycles = 0;
  bit   hold_request = 1'b0;

  kci_in_if  in_ch();
  kci_out_if out_ch();

  keyframe_curve_interpolator_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  kci_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The long output stall is timed here, apart from the random ready.
  always @(posedge clk) begin
    if (hold_request && hold_cycles == 0) hold_cycles <= 400;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_cycles > 1) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_segment(logic [2:0] mode, logic [31:0] start_v, logic [31:0] end_v,
                              logic [23:0] dur, logic [23:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.start_value <= start_v;
    in_ch.end_value <= end_v;
    in_ch.segment_length <= dur;
    in_ch.offset_in_segment <= pos;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_random;
    logic [2:0]  mode;
    logic [31:0] sv, ev;
    logic [23:0] dur, pos;
    mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    sv = $urandom;
    ev = ($urandom_range(3) == 0) ? sv + 32'($signed($urandom_range(4000)) - 2000) : $urandom;
    case ($urandom_range(3))
      0: dur = 24'($urandom_range(16));
      1: dur = 24'($urandom_range(4096));
      default: dur = 24'($urandom);
    endcase
    if ($urandom_range(15) == 0) dur = 24'd0;
    pos = ($urandom_range(7) == 0) ? 24'($urandom) : 24'(({32'd0, $urandom} * (dur + 1)) >> 32);
    send_segment(mode, sv, ev, dur, pos);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.start_value = '0;
    in_ch.end_value = '0;
    in_ch.segment_length = '0;
    in_ch.offset_in_segment = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every mode, value extremes, zero duration, position past end.
    send_segment(kci_pkg::MODE_HOLD,   32'h8000_0000, 32'h7FFF_FFFF, 24'd100, 24'd50);
    send_segment(kci_pkg::MODE_LINEAR, 32'h8000_0000, 32'h7FFF_FFFF, 24'd2, 24'd1);
    send_segment(kci_pkg::MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 24'hFFFFFE);
    send_segment(kci_pkg::MODE_FAST,   32'h8000_0000, 32'h7FFF_FFFF, 24'd3, 24'd1);
    send_segment(kci_pkg::MODE_SLOW,   32'h7FFF_FFFF, 32'h8000_0000, 24'd3, 24'd2);
    send_segment(kci_pkg::MODE_SMOOTH, 32'h0000_0000, 32'h0001_0000, 24'd512, 24'd256);
    send_segment(kci_pkg::MODE_SMOOTH, 32'h8000_0000, 32'h7FFF_FFFF, 24'd1000, 24'd999);
    send_segment(kci_pkg::MODE_SMOOTH, 32'h7FFF_FFFF, 32'h8000_0000, 24'd7, 24'd1);
    send_segment(kci_pkg::MODE_LINEAR, 32'h0001_0000, 32'h0005_0000, 24'd10, 24'hFFFFFF);
    send_segment(kci_pkg::MODE_SMOOTH, 32'h0001_0000, 32'hFFFB_0000, 24'd1, 24'd5);
    send_segment(kci_pkg::MODE_FAST,   32'h1234_5678, 32'h8765_4321, 24'hFFFFFF, 24'd0);
    send_segment(kci_pkg::MODE_SLOW,   32'h1234_5678, 32'h8765_4321, 24'hFFFFFF, 24'hFFFFFF);
    send_segment(kci_pkg::MODE_LINEAR, 32'h0000_1111, 32'h0000_2222, 24'd0, 24'd0);
    send_segment(kci_pkg::MODE_SMOOTH, 32'hFFFF_FFFF, 32'h0000_0000, 24'd0, 24'hFFFFFF);
    send_segment(3'd5,        32'hAAAA_AAAA, 32'h5555_5555, 24'd10, 24'd5);
    send_segment(3'd6,        32'h5555_5555, 32'hAAAA_AAAA, 24'hAAAAAA, 24'h555555);
    send_segment(3'd7,        32'h7FFF_FFFF, 32'h0, 24'h555555, 24'hAAAAAA);
    send_segment(kci_pkg::MODE_HOLD,   32'hFFFF_FFFF, 32'h0, 24'd1, 24'd1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 17;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
      end else if (n == 2 * RANDOM_ITEMS / 3 + 5) begin
        hold_request = 1'b0;
      end
      send_random();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d query beats and %0d checked results across all curve modes,",
             sent, checked);
    $display("zero durations, invalid modes and overshooting positions under stalls.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
